/* rtl/core/hlr_pkg.sv */
// Shared constants, types and state encoding for the histogram largest-rectangle core.
`default_nettype none
package hlr_pkg;

  localparam int unsigned MaxBarsDef    = 1024;
  localparam int unsigned HeightBitsDef = 16;

  // Fixed stream field widths
  localparam int unsigned BarW      = 16;
  localparam int unsigned AreaOutW  = 26;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_CMP_WAIT,
    S_FLUSH,
    S_FLUSH_WAIT,
    S_DRAIN,
    S_RESULT
  } hlr_state_e;

  // Control from the sequencer to the area unit
  typedef struct packed {
    logic score;  // operands valid this cycle
    logic clear;  // start a new histogram
  } hlr_area_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/hlr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module hlr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/core/hlr_area.sv */
// Area scoring unit: registered operands, registered product, running maximum.
`default_nettype none
module hlr_area #(
  parameter int unsigned HgtW  = 16,
  parameter int unsigned WidW  = 11,
  parameter int unsigned AreaW = HgtW + WidW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hlr_pkg::hlr_area_ctrl_t      ctrl_i,
  input  logic [HgtW-1:0]              height_i,
  input  logic [WidW-1:0]              width_i,
  output logic [AreaW-1:0]             best_o
);
  import hlr_pkg::*;

  logic             op_v_q, prod_v_q;
  logic [HgtW-1:0]  op_h_q;
  logic [WidW-1:0]  op_w_q;
  logic [AreaW-1:0] prod_q;
  logic [AreaW-1:0] best_q, best_d;

  always_comb begin
    best_d = best_q;
    if (ctrl_i.clear) begin
      best_d = '0;
    end else if (prod_v_q && (prod_q > best_q)) begin
      best_d = prod_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
      best_q   <= '0;
    end else begin
      op_v_q   <= ctrl_i.score & ~ctrl_i.clear;
      prod_v_q <= op_v_q & ~ctrl_i.clear;
      best_q   <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.score) begin
      op_h_q <= height_i;
      op_w_q <= width_i;
    end
    prod_q <= AreaW'(op_h_q) * AreaW'(op_w_q);
  end

  assign best_o = best_q;

endmodule
`default_nettype wire

/* rtl/core/histogram_largest_rectangle_core.sv */
// Top level of the histogram largest-rectangle core: stream ports, stack sequencer, RAM.
`default_nettype none
// Bars stream in one per transaction (height in s_axis_tdata, final bar marked by
// s_axis_tlast). The core keeps a monotonic stack of (start index, height) pairs;
// the top entry lives in registers and the entries below it in a single RAM with
// registered read data. Each bar passes an accept step and a compare/push step,
// plus a compare and a wait step for every entry it pops, since each pop must
// wait on the RAM read that refills the cached top; a dropped bar is only accepted.
// After the final bar the remaining stack is flushed with a score step and a wait
// step per entry, then the multiply/compare pipe drains and the result moves into
// the output register, from where the single result transaction is offered.
// Result: max_area (low 26 bits of the best area) and an overflow flag set when
// more than MaxBars bars arrived; extra bars are dropped but their tlast still
// ends the histogram. Stack fill, bar count, overflow flag and best area return to
// zero once the result is in the output register, so the next histogram streams
// in while the result waits; only a second finished one stalls until it is taken.
module histogram_largest_rectangle_core #(
  parameter int unsigned MaxBars    = hlr_pkg::MaxBarsDef,
  parameter int unsigned HeightBits = hlr_pkg::HeightBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [hlr_pkg::InDataW-1:0]   s_axis_tdata,   // [15:0] bar_height
  input  logic                          s_axis_tlast,   // last_bar
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [hlr_pkg::OutDataW-1:0]  m_axis_tdata,   // [25:0] max_area, [31:26] zero
  output logic                          m_axis_tuser    // overflowed
);
  import hlr_pkg::*;

  // Heights above the stream field width cannot occur
  localparam int unsigned HgtW  = (HeightBits < BarW) ? HeightBits : BarW;
  localparam int unsigned PosW  = $clog2(MaxBars);
  localparam int unsigned CntW  = $clog2(MaxBars + 1);
  localparam int unsigned AreaW = HgtW + CntW;
  localparam int unsigned EntW  = PosW + HgtW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxBars);

  hlr_state_e state_q, state_d;

  logic [CntW-1:0] fill_q, fill_d;     // entries on stack, including cached top
  logic [CntW-1:0] bars_q, bars_d;
  logic            ovf_q, ovf_d;
  logic            last_q, last_d;
  logic [HgtW-1:0] h_q, h_d;           // bar being placed
  logic [PosW-1:0] start_q, start_d;   // its inherited start index
  logic [PosW-1:0] top_pos_q, top_pos_d;
  logic [HgtW-1:0] top_h_q, top_h_d;

  // result holding register
  logic                out_v_q, out_v_d;
  logic [AreaOutW-1:0] out_area_q, out_area_d;
  logic                out_ovf_q, out_ovf_d;

  logic            ram_we;
  logic [PosW-1:0] ram_waddr, ram_raddr;
  logic [EntW-1:0] ram_wdata, ram_rdata;

  hlr_area_ctrl_t  area_ctrl;
  logic [CntW-1:0] score_w;
  logic [AreaW-1:0] best;

  // Best area zero-extended, then cut to the result field
  logic [AreaW+AreaOutW-1:0] best_ext;

  logic [CntW-1:0] fill_m1, fill_m2;
  logic            top_ok;

  assign fill_m1 = fill_q - CntW'(1);
  assign fill_m2 = fill_q - CntW'(2);
  assign top_ok  = (fill_q != '0);
  // rectangle of the top entry ends just before the current bar index
  assign score_w = bars_q - CntW'(top_pos_q);
  assign best_ext = {{AreaOutW{1'b0}}, best};

  always_comb begin
    state_d       = state_q;
    fill_d        = fill_q;
    bars_d        = bars_q;
    ovf_d         = ovf_q;
    last_d        = last_q;
    h_d           = h_q;
    start_d       = start_q;
    top_pos_d     = top_pos_q;
    top_h_d       = top_h_q;
    out_v_d       = out_v_q & ~m_axis_tready;
    out_area_d    = out_area_q;
    out_ovf_d     = out_ovf_q;
    ram_we        = 1'b0;
    ram_waddr     = fill_m1[PosW-1:0];
    ram_wdata     = {top_pos_q, top_h_q};
    ram_raddr     = fill_m2[PosW-1:0];
    area_ctrl     = '0;
    s_axis_tready = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (bars_q == MaxCnt) begin
            ovf_d   = 1'b1;
            state_d = s_axis_tlast ? S_FLUSH : S_IDLE;
          end else begin
            h_d     = s_axis_tdata[HgtW-1:0];
            start_d = bars_q[PosW-1:0];
            last_d  = s_axis_tlast;
            state_d = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (top_ok && (top_h_q >= h_q)) begin
          // pop: score top, fetch the entry below it
          area_ctrl.score = 1'b1;
          start_d         = top_pos_q;
          fill_d          = fill_m1;
          state_d         = S_CMP_WAIT;
        end else begin
          // push: spill cached top to RAM, cache the new bar
          ram_we    = top_ok;
          top_pos_d = start_q;
          top_h_d   = h_q;
          fill_d    = fill_q + CntW'(1);
          bars_d    = bars_q + CntW'(1);
          state_d   = last_q ? S_FLUSH : S_IDLE;
        end
      end
      S_CMP_WAIT: begin
        if (top_ok) begin
          {top_pos_d, top_h_d} = ram_rdata;
        end
        state_d = S_CMP;
      end
      S_FLUSH: begin
        if (top_ok) begin
          area_ctrl.score = 1'b1;
          fill_d          = fill_m1;
          state_d         = S_FLUSH_WAIT;
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_FLUSH_WAIT: begin
        if (top_ok) begin
          {top_pos_d, top_h_d} = ram_rdata;
        end
        state_d = S_FLUSH;
      end
      S_DRAIN: begin
        state_d = S_RESULT;
      end
      S_RESULT: begin
        // hand over once the output register is free or emptied this cycle
        if (!out_v_q || m_axis_tready) begin
          out_v_d         = 1'b1;
          out_area_d      = best_ext[AreaOutW-1:0];
          out_ovf_d       = ovf_q;
          area_ctrl.clear = 1'b1;
          fill_d          = '0;
          bars_d          = '0;
          ovf_d           = 1'b0;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      bars_q  <= '0;
      ovf_q   <= 1'b0;
      last_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bars_q  <= bars_d;
      ovf_q   <= ovf_d;
      last_q  <= last_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q        <= h_d;
    start_q    <= start_d;
    top_pos_q  <= top_pos_d;
    top_h_q    <= top_h_d;
    out_area_q <= out_area_d;
    out_ovf_q  <= out_ovf_d;
  end

  hlr_ram #(
    .Width (EntW),
    .Depth (MaxBars)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  hlr_area #(
    .HgtW  (HgtW),
    .WidW  (CntW),
    .AreaW (AreaW)
  ) u_area (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (area_ctrl),
    .height_i (top_h_q),
    .width_i  (score_w),
    .best_o   (best)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(OutDataW-AreaOutW){1'b0}}, out_area_q};
  assign m_axis_tuser  = out_ovf_q;

endmodule
`default_nettype wire

/* dv/hlr_checker.sv */
`timescale 1ns / 100ps
// Stream monitor for the histogram core: mirrors the bar stack, predicts each area, compares.
module hlr_checker #(
  parameter int unsigned MaxBars = hlr_pkg::MaxBarsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [hlr_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                         s_tlast_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [hlr_pkg::OutDataW-1:0] m_tdata_i,
  input  logic                         m_tuser_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import hlr_pkg::*;

  typedef struct packed {
    logic [AreaOutW-1:0] area;
    logic                ovf;
  } hist_result_t;

  hist_result_t    expected_areas[$];

  // Mirror of the monotonic stack: start index and height of each open run
  int unsigned     run_start  [MaxBars];
  logic [BarW-1:0] run_height [MaxBars];
  int unsigned     run_depth;
  int unsigned     bar_count;
  longint unsigned best_area;
  bit              too_many;

  // Close the top run at end_pos, score it, hand back its start index
  function automatic int unsigned close_run(int unsigned end_pos);
    int unsigned     top;
    longint unsigned area;
    top  = run_depth - 1;
    area = 64'(run_height[top]) * 64'(end_pos - run_start[top]);
    if (area > best_area) best_area = area;
    run_depth = top;
    return run_start[top];
  endfunction

  function automatic void take_bar(logic [BarW-1:0] height, logic last);
    int unsigned  start;
    hist_result_t res;
    if (bar_count >= MaxBars) begin
      too_many = 1'b1;           // bar dropped, only its tlast counts
    end else begin
      start = bar_count;
      while (run_depth > 0 && run_height[run_depth-1] >= height)
        start = close_run(bar_count);
      run_start[run_depth]  = start;
      run_height[run_depth] = height;
      run_depth++;
      bar_count++;
    end
    if (last) begin
      while (run_depth > 0) void'(close_run(bar_count));
      res.area = best_area[AreaOutW-1:0];
      res.ovf  = too_many;
      expected_areas.insert(expected_areas.size(), res);
      run_depth = 0;
      bar_count = 0;
      best_area = 0;
      too_many  = 1'b0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    hist_result_t want;
    if (!rst_ni) begin
      expected_areas.delete();
      run_depth    = 0;
      bar_count    = 0;
      best_area    = 0;
      too_many     = 1'b0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_areas.size() == 0) begin
          fail_count_o++;
          $error("unexpected result: max_area=%0d overflowed=%0b",
                 m_tdata_i[AreaOutW-1:0], m_tuser_i);
        end else begin
          want = expected_areas.pop_front();
          if (m_tdata_i[AreaOutW-1:0] !== want.area) begin
            fail_count_o++;
            $error("max_area mismatch: expected %0d, got %0d",
                   want.area, m_tdata_i[AreaOutW-1:0]);
          end
          if (m_tuser_i !== want.ovf) begin
            fail_count_o++;
            $error("overflowed mismatch: expected %0b, got %0b", want.ovf, m_tuser_i);
          end
          if (m_tdata_i[OutDataW-1:AreaOutW] !== '0) begin
            fail_count_o++;
            $error("tdata pad mismatch: expected 0, got 'h%0h",
                   m_tdata_i[OutDataW-1:AreaOutW]);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) take_bar(s_tdata_i[BarW-1:0], s_tlast_i);
      pending_o = expected_areas.size();
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Top of the histogram core bench: clock, reset, bar stimulus, result back-pressure, verdict.
module testbench;
  import hlr_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam int          BarTarget = 1850;
  localparam int          QuietTail = 1650;    // no idling past this many bars

  logic                clk;
  logic                rst_n;
  logic                s_valid, s_ready, s_last;
  logic [InDataW-1:0]  s_data;
  logic                m_valid, m_ready, m_user;
  logic [OutDataW-1:0] m_data;

  bit src_gaps, sink_gaps;
  int sink_hold;
  int bars_sent;
  int fails, pending;

  histogram_largest_rectangle_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user)
  );

  hlr_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_data),
    .s_tlast_i    (s_last),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_data),
    .m_tuser_i    (m_user),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side back-pressure: random stall bursts while sink_gaps is set
  initial begin
    m_ready   = 1'b0;
    sink_hold = 0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        sink_hold--;
        m_ready <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        sink_hold = $urandom_range(1, 17) - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
      else quiet++;
    end
    $display("** histogram_largest_rectangle_core: FAILED **");
    $finish;
  end

  // One bar transaction; entered and left at a falling edge
  task automatic put_bar(input int height, input bit last);
    int gap;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= height[BarW-1:0];
    s_last  <= last;
    do @(posedge clk); while (!s_ready);
    bars_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every expected area has come back
  task automatic wait_results();
    s_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    int len, mode, h, hists, step;
    s_valid   = 1'b0;
    s_data    = '0;
    s_last    = 1'b0;
    rst_n     = 1'b0;
    bars_sent = 0;
    hists     = 0;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: single bars at both extremes, equal runs, monotone, dips, zeros
    put_bar(0, 1'b1);
    put_bar(65535, 1'b1);
    put_bar(5, 1'b0); put_bar(5, 1'b0); put_bar(5, 1'b1);
    put_bar(9, 1'b0); put_bar(7, 1'b0); put_bar(3, 1'b1);
    put_bar(1, 1'b0); put_bar(2, 1'b0); put_bar(3, 1'b0); put_bar(4, 1'b1);
    put_bar(6, 1'b0); put_bar(2, 1'b0); put_bar(5, 1'b0); put_bar(4, 1'b0);
    put_bar(5, 1'b0); put_bar(1, 1'b0); put_bar(6, 1'b1);
    put_bar(65535, 1'b0); put_bar(65535, 1'b1);
    put_bar(4, 1'b0); put_bar(0, 1'b0); put_bar(4, 1'b1);
    wait_results();

    // Full stack: 1024 strictly rising bars, then dropped bars, tlast on a dropped one
    h = $urandom_range(0, 50);
    for (int i = 0; i < MaxBarsDef; i++) begin
      put_bar(h, 1'b0);
      h += $urandom_range(1, 63);
    end
    put_bar($urandom_range(0, 65535), 1'b0);
    put_bar($urandom_range(0, 65535), 1'b0);
    put_bar($urandom_range(0, 65535), 1'b1);
    wait_results();

    // Random histograms, mostly short, content shaped by a per-histogram mode
    while (bars_sent < BarTarget) begin
      if (bars_sent > QuietTail) begin
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
      end else begin
        src_gaps  = ($urandom_range(0, 3) != 0);
        sink_gaps = ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(1, 8);
        6, 7, 8:          len = $urandom_range(9, 40);
        default:          len = $urandom_range(41, 150);
      endcase
      mode = $urandom_range(0, 4);
      h    = $urandom_range(0, 65535);
      step = $urandom_range(0, 600);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: h = $urandom_range(0, 65535);
          1: h = $urandom_range(0, 7);           // many equal heights
          2: begin
            case ($urandom_range(0, 3))
              0: h = 0;
              1: h = 1;
              2: h = 65534;
              default: h = 65535;
            endcase
          end
          3: h = (h + $urandom_range(0, step) > 65535) ? 65535 : h + $urandom_range(0, step);
          default: h = (h < step) ? $urandom_range(0, 3) : h - $urandom_range(0, step);
        endcase
        put_bar(h, i == len - 1);
      end
      hists++;
      if (hists % 40 == 0) wait_results();
    end

    s_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (50) @(negedge clk);
    if (fails == 0) begin
      $display("** histogram_largest_rectangle_core: PASSED **");
    end else begin
      $display("** histogram_largest_rectangle_core: FAILED **");
    end
    $finish;
  end

endmodule
